### design/spms_pkg.sv
`default_nettype none

package spms_pkg;

    // Raw field widths
    localparam int RAW_W           = 16;
    localparam int BUS_STATUS_BITS = 3;
    localparam int BUS_VAL_W       = RAW_W - BUS_STATUS_BITS;

    // Result field widths
    localparam int BUS_MV_W   = 15;
    localparam int SHUNT_MV_W = 10;
    localparam int CUR_W      = 20;
    localparam int PWR_W      = 35;

    // Magnitude widths inside the datapath
    localparam int SH_MAG_W    = 16;   // |shunt| up to 32768
    localparam int BUS40_W     = 19;   // bus * 40 up to 327640
    localparam int CUR_MAG_W   = 19;   // |shunt| * 10 up to 327680
    localparam int PWR_MAG_W   = 34;   // bus * |shunt| * 40
    localparam int SH_MV_MAG_W = 9;    // |shunt| / 100 up to 327

    // Scale factors
    localparam int BUS_MV_PER_STEP = 4;
    localparam int CURRENT_SCALE   = 10;
    localparam int POWER_SCALE     = 40;

    // |shunt| / 100 as a reciprocal multiply, exact for values below 43690
    localparam int SH_RECIP       = 5243;
    localparam int SH_RECIP_SHIFT = 19;
    localparam int SH_RECIP_PROD_W = SH_MAG_W + 13;

    // Fields that ride alongside the divider
    typedef struct packed {
        logic [BUS_MV_W-1:0]          bus_mv;
        logic signed [SHUNT_MV_W-1:0] shunt_mv;
        logic                         neg;
    } t_side;

endpackage

`default_nettype wire

### design/shunt_power_monitor_scaler.sv
`default_nettype none

// Converts raw bus/shunt readings of a hot-swap power monitor into bus mV,
// shunt mV, current in mA and power in uW, all divisions truncating toward
// zero. One beat is accepted per clock while the output side keeps up; the
// pipelined divider retires DIV_STEP_BITS quotient bits per stage for current
// and power in parallel. A stall on the output holds the whole pipeline. The
// shunt resistance register resets to 1 milliohm, a write of zero is stored
// as 1, and it must only be written while no beat is in flight.
module shunt_power_monitor_scaler #(
    parameter int DIV_STEP_BITS = 4   // 1..8
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    // configuration write
    input  wire logic                                    i_cfg_valid,
    output logic                                         o_cfg_ready,
    input  wire logic [15:0]                             i_cfg_shunt_milliohms,
    // input readings
    input  wire logic                                    i_in_valid,
    output logic                                         o_in_ready,
    input  wire logic [spms_pkg::RAW_W-1:0]              i_bus_raw,
    input  wire logic signed [spms_pkg::RAW_W-1:0]       i_shunt_raw,
    // scaled results
    output logic                                         o_out_valid,
    input  wire logic                                    i_out_ready,
    output logic [spms_pkg::BUS_MV_W-1:0]                o_bus_millivolts,
    output logic signed [spms_pkg::SHUNT_MV_W-1:0]       o_shunt_millivolts,
    output logic signed [spms_pkg::CUR_W-1:0]            o_current_milliamps,
    output logic signed [spms_pkg::PWR_W-1:0]            o_power_microwatts
);

    localparam int DIV_W = ((spms_pkg::PWR_MAG_W + DIV_STEP_BITS - 1) / DIV_STEP_BITS)
                           * DIV_STEP_BITS;
    localparam int DIV_STAGES = DIV_W / DIV_STEP_BITS;
    localparam int NV         = DIV_STAGES + 3;
    localparam int OUT_IDX    = NV - 1;

    logic en;

    // Shunt resistance register, zero stored as one
    logic [15:0] r_shunt_milliohms;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shunt_milliohms <= 16'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_shunt_milliohms <= (i_cfg_shunt_milliohms == 16'd0) ? 16'd1
                                                                   : i_cfg_shunt_milliohms;
        end
    end

    // Global stall: everything moves when the output slot is free or drains
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    // Valid bits travel with the data
    logic [NV-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NV-2:0], i_in_valid};
        end
    end

    // Stage A: sign split, magnitudes, constant scalings
    logic [spms_pkg::BUS_VAL_W-1:0] bus_val;
    logic                           sh_neg;
    logic [spms_pkg::SH_MAG_W-1:0]  sh_mag;

    assign bus_val = i_bus_raw[spms_pkg::RAW_W-1:spms_pkg::BUS_STATUS_BITS];
    assign sh_neg  = i_shunt_raw[spms_pkg::RAW_W-1];
    assign sh_mag  = sh_neg ? (~i_shunt_raw + 16'd1) : i_shunt_raw;

    logic [spms_pkg::BUS_VAL_W-1:0] r_a_bus;
    logic [spms_pkg::BUS40_W-1:0]   r_a_bus40;
    logic [spms_pkg::SH_MAG_W-1:0]  r_a_shmag;
    logic [spms_pkg::CUR_MAG_W-1:0] r_a_curmag;
    logic                           r_a_neg;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_bus    <= bus_val;
            r_a_bus40  <= spms_pkg::BUS40_W'(bus_val)
                          * spms_pkg::BUS40_W'(spms_pkg::POWER_SCALE);
            r_a_shmag  <= sh_mag;
            r_a_curmag <= spms_pkg::CUR_MAG_W'(sh_mag)
                          * spms_pkg::CUR_MAG_W'(spms_pkg::CURRENT_SCALE);
            r_a_neg    <= sh_neg;
        end
    end

    // Stage B: power product, shunt mV by reciprocal, bus mV
    logic [spms_pkg::PWR_MAG_W-1:0]       pwr_prod;
    logic [spms_pkg::SH_RECIP_PROD_W-1:0] shmv_prod;
    logic [spms_pkg::SH_MV_MAG_W-1:0]     shmv_mag;
    logic [spms_pkg::SHUNT_MV_W-1:0]      shmv_ext;
    spms_pkg::t_side                      b_side;

    assign pwr_prod  = spms_pkg::PWR_MAG_W'(r_a_bus40) * spms_pkg::PWR_MAG_W'(r_a_shmag);
    assign shmv_prod = spms_pkg::SH_RECIP_PROD_W'(r_a_shmag)
                       * spms_pkg::SH_RECIP_PROD_W'(spms_pkg::SH_RECIP);
    assign shmv_mag  = shmv_prod[spms_pkg::SH_RECIP_SHIFT +: spms_pkg::SH_MV_MAG_W];
    assign shmv_ext  = {1'b0, shmv_mag};

    always_comb begin
        b_side.bus_mv   = spms_pkg::BUS_MV_W'(r_a_bus)
                          * spms_pkg::BUS_MV_W'(spms_pkg::BUS_MV_PER_STEP);
        b_side.shunt_mv = r_a_neg ? $signed(-shmv_ext) : $signed(shmv_ext);
        b_side.neg      = r_a_neg;
    end

    logic [spms_pkg::PWR_MAG_W-1:0] r_b_pwr;
    logic [spms_pkg::CUR_MAG_W-1:0] r_b_cur;
    spms_pkg::t_side                r_b_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_pwr  <= pwr_prod;
            r_b_cur  <= r_a_curmag;
            r_b_side <= b_side;
        end
    end

    // Divider stages: power and current in lockstep
    logic [DIV_W-1:0] pwr_quo;
    logic [DIV_W-1:0] cur_quo;

    spms_udiv #(
        .NUM_W     (DIV_W),
        .DEN_W     (16),
        .STEP_BITS (DIV_STEP_BITS)
    ) u_div_pwr (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (DIV_W'(r_b_pwr)),
        .i_den (r_shunt_milliohms),
        .o_quo (pwr_quo)
    );

    spms_udiv #(
        .NUM_W     (DIV_W),
        .DEN_W     (16),
        .STEP_BITS (DIV_STEP_BITS)
    ) u_div_cur (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (DIV_W'(r_b_cur)),
        .i_den (r_shunt_milliohms),
        .o_quo (cur_quo)
    );

    // Side fields delayed to match the divider
    spms_pkg::t_side r_side [DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= r_b_side;
            for (int s = 1; s < DIV_STAGES; s++) begin
                r_side[s] <= r_side[s-1];
            end
        end
    end

    // Output stage: restore signs
    spms_pkg::t_side               d_side;
    logic [spms_pkg::CUR_W-1:0]    cur_m;
    logic [spms_pkg::PWR_W-1:0]    pwr_m;

    assign d_side = r_side[DIV_STAGES-1];
    assign cur_m  = spms_pkg::CUR_W'(cur_quo);
    assign pwr_m  = spms_pkg::PWR_W'(pwr_quo);

    logic [spms_pkg::BUS_MV_W-1:0]   r_o_bus_mv;
    logic [spms_pkg::SHUNT_MV_W-1:0] r_o_shunt_mv;
    logic [spms_pkg::CUR_W-1:0]      r_o_cur;
    logic [spms_pkg::PWR_W-1:0]      r_o_pwr;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_bus_mv   <= d_side.bus_mv;
            r_o_shunt_mv <= d_side.shunt_mv;
            r_o_cur      <= d_side.neg ? -cur_m : cur_m;
            r_o_pwr      <= d_side.neg ? -pwr_m : pwr_m;
        end
    end

    assign o_out_valid         = r_vld[OUT_IDX];
    assign o_bus_millivolts    = r_o_bus_mv;
    assign o_shunt_millivolts  = $signed(r_o_shunt_mv);
    assign o_current_milliamps = $signed(r_o_cur);
    assign o_power_microwatts  = $signed(r_o_pwr);

    // Checks
    a_res_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_shunt_milliohms != 16'd0)
        else $error("shunt resistance register holds zero");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipeline valid bits moved during a stall");

    a_pwr_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_power_microwatts[spms_pkg::PWR_W-1]
        |-> (o_current_milliamps[spms_pkg::CUR_W-1] || o_current_milliamps == '0))
        else $error("negative power with positive current");

    a_bus_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_bus_millivolts[1:0] == 2'b00)
        else $error("bus millivolts not a multiple of the step");

endmodule

`default_nettype wire

### design/spms_udiv.sv
`default_nettype none

// Pipelined unsigned restoring divider, STEP_BITS quotient bits per stage.
// The divisor must stay stable while beats are in flight.
module spms_udiv #(
    parameter int NUM_W     = 36,
    parameter int DEN_W     = 16,
    parameter int STEP_BITS = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic      [NUM_W-1:0] o_quo
);

    localparam int STAGES = NUM_W / STEP_BITS;
    localparam int REM_W  = DEN_W + 1;

    logic [REM_W-1:0] r_rem [STAGES];
    logic [NUM_W-1:0] r_num [STAGES];
    logic [REM_W-1:0] n_rem [STAGES];
    logic [NUM_W-1:0] n_num [STAGES];

    // STEP_BITS shift/compare/subtract steps; quotient bits enter num from the right
    function automatic logic [REM_W+NUM_W-1:0] div_steps(
        input logic [REM_W-1:0] rem_in,
        input logic [NUM_W-1:0] num_in,
        input logic [DEN_W-1:0] den
    );
        logic [REM_W-1:0] rem;
        logic [NUM_W-1:0] num;
        logic [REM_W:0]   diff;
        rem = rem_in;
        num = num_in;
        for (int k = 0; k < STEP_BITS; k++) begin
            rem  = {rem[REM_W-2:0], num[NUM_W-1]};
            num  = {num[NUM_W-2:0], 1'b0};
            diff = {1'b0, rem} - {2'b00, den};
            if (!diff[REM_W]) begin
                rem    = diff[REM_W-1:0];
                num[0] = 1'b1;
            end
        end
        return {rem, num};
    endfunction

    // Next value of every stage
    always_comb begin
        for (int s = 0; s < STAGES; s++) begin
            if (s == 0) begin
                {n_rem[s], n_num[s]} = div_steps('0, i_num, i_den);
            end else begin
                {n_rem[s], n_num[s]} = div_steps(r_rem[s-1], r_num[s-1], i_den);
            end
        end
    end

    // Stage registers advance together
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < STAGES; s++) begin
                r_rem[s] <= n_rem[s];
                r_num[s] <= n_num[s];
            end
        end
    end

    assign o_quo = r_num[STAGES-1];

endmodule

`default_nettype wire
